FILE: sv/x86_16_opcode_class_decoder_top_defines.svh
// ============================================================================
// x86 opcode class decoder assertion macros
// Shared property wrappers for the port-level checker.
// ============================================================================
`ifndef X86_16_OPCODE_CLASS_DECODER_TOP_DEFINES_SVH
`define X86_16_OPCODE_CLASS_DECODER_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while reset is asserted.
`define X86OC_ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("x86oc checker: same-cycle property failed");

// Next-cycle implication, sampled on clk, off while reset is asserted.
`define X86OC_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("x86oc checker: next-cycle property failed");

`endif

FILE: sv/x86oc_pkg.sv
// ============================================================================
// x86 opcode class decoder package
// Mnemonic class codes, group lookup tables and the decode result type.
// ============================================================================
package x86oc_pkg;

	typedef logic [6:0] cls_t;

	typedef struct packed {
		cls_t mnemonic_class;
		logic decode_valid;
	} decode_t;

	localparam cls_t CLS_NONE   = 7'd0;
	localparam cls_t CLS_AAA    = 7'd0;
	localparam cls_t CLS_AAD    = 7'd1;
	localparam cls_t CLS_AAM    = 7'd2;
	localparam cls_t CLS_AAS    = 7'd3;
	localparam cls_t CLS_ADC    = 7'd4;
	localparam cls_t CLS_ADD    = 7'd5;
	localparam cls_t CLS_AND    = 7'd6;
	localparam cls_t CLS_CALL   = 7'd7;
	localparam cls_t CLS_CALLF  = 7'd8;
	localparam cls_t CLS_CBW    = 7'd9;
	localparam cls_t CLS_CLC    = 7'd10;
	localparam cls_t CLS_CLD    = 7'd11;
	localparam cls_t CLS_CLI    = 7'd12;
	localparam cls_t CLS_CMC    = 7'd13;
	localparam cls_t CLS_CMP    = 7'd14;
	localparam cls_t CLS_CMPS   = 7'd15;
	localparam cls_t CLS_CWD    = 7'd16;
	localparam cls_t CLS_DAA    = 7'd17;
	localparam cls_t CLS_DAS    = 7'd18;
	localparam cls_t CLS_DEC    = 7'd19;
	localparam cls_t CLS_DIV    = 7'd20;
	localparam cls_t CLS_HLT    = 7'd22;
	localparam cls_t CLS_IDIV   = 7'd23;
	localparam cls_t CLS_IMUL   = 7'd24;
	localparam cls_t CLS_IN     = 7'd25;
	localparam cls_t CLS_INC    = 7'd26;
	localparam cls_t CLS_INS    = 7'd27;
	localparam cls_t CLS_INT    = 7'd28;
	localparam cls_t CLS_INTO   = 7'd29;
	localparam cls_t CLS_IRET   = 7'd30;
	localparam cls_t CLS_JA     = 7'd31;
	localparam cls_t CLS_JB     = 7'd35;
	localparam cls_t CLS_JCXZ   = 7'd36;
	localparam cls_t CLS_JG     = 7'd38;
	localparam cls_t CLS_JGE    = 7'd40;
	localparam cls_t CLS_JMP    = 7'd42;
	localparam cls_t CLS_JMPF   = 7'd43;
	localparam cls_t CLS_JBE    = 7'd44;
	localparam cls_t CLS_JAE    = 7'd48;
	localparam cls_t CLS_JLE    = 7'd50;
	localparam cls_t CLS_JL     = 7'd52;
	localparam cls_t CLS_JNO    = 7'd54;
	localparam cls_t CLS_JNP    = 7'd55;
	localparam cls_t CLS_JNS    = 7'd56;
	localparam cls_t CLS_JNE    = 7'd57;
	localparam cls_t CLS_JO     = 7'd58;
	localparam cls_t CLS_JP     = 7'd59;
	localparam cls_t CLS_JS     = 7'd62;
	localparam cls_t CLS_JE     = 7'd63;
	localparam cls_t CLS_LAHF   = 7'd64;
	localparam cls_t CLS_LDS    = 7'd65;
	localparam cls_t CLS_LEA    = 7'd66;
	localparam cls_t CLS_LES    = 7'd68;
	localparam cls_t CLS_LODS   = 7'd70;
	localparam cls_t CLS_LOOP   = 7'd71;
	localparam cls_t CLS_LOOPZ  = 7'd74;
	localparam cls_t CLS_LOOPNZ = 7'd75;
	localparam cls_t CLS_MOV    = 7'd76;
	localparam cls_t CLS_MOVS   = 7'd77;
	localparam cls_t CLS_MUL    = 7'd78;
	localparam cls_t CLS_NEG    = 7'd79;
	localparam cls_t CLS_NOP    = 7'd80;
	localparam cls_t CLS_NOT    = 7'd81;
	localparam cls_t CLS_OR     = 7'd82;
	localparam cls_t CLS_OUT    = 7'd83;
	localparam cls_t CLS_OUTS   = 7'd84;
	localparam cls_t CLS_POP    = 7'd85;
	localparam cls_t CLS_POPA   = 7'd86;
	localparam cls_t CLS_POPF   = 7'd87;
	localparam cls_t CLS_PUSH   = 7'd88;
	localparam cls_t CLS_PUSHA  = 7'd89;
	localparam cls_t CLS_PUSHF  = 7'd90;
	localparam cls_t CLS_RCL    = 7'd91;
	localparam cls_t CLS_RCR    = 7'd92;
	localparam cls_t CLS_RET    = 7'd97;
	localparam cls_t CLS_ROL    = 7'd98;
	localparam cls_t CLS_ROR    = 7'd99;
	localparam cls_t CLS_SAHF   = 7'd100;
	localparam cls_t CLS_SAR    = 7'd102;
	localparam cls_t CLS_SBB    = 7'd103;
	localparam cls_t CLS_SCAS   = 7'd104;
	localparam cls_t CLS_SHL    = 7'd105;
	localparam cls_t CLS_SHR    = 7'd106;
	localparam cls_t CLS_STC    = 7'd107;
	localparam cls_t CLS_STD    = 7'd108;
	localparam cls_t CLS_STI    = 7'd109;
	localparam cls_t CLS_STOS   = 7'd110;
	localparam cls_t CLS_SUB    = 7'd111;
	localparam cls_t CLS_WAIT   = 7'd113;
	localparam cls_t CLS_XCHG   = 7'd114;
	localparam cls_t CLS_XLAT   = 7'd115;
	localparam cls_t CLS_XOR    = 7'd116;

	// Arithmetic row of the primary map, selected by opcode bits 5:3.
	function automatic cls_t alu_row(input logic [2:0] sel);
		cls_t r;
		case (sel)
			3'd0: r = CLS_ADD;
			3'd1: r = CLS_OR;
			3'd2: r = CLS_ADC;
			3'd3: r = CLS_SBB;
			3'd4: r = CLS_AND;
			3'd5: r = CLS_SUB;
			3'd6: r = CLS_XOR;
			default: r = CLS_CMP;
		endcase
		return r;
	endfunction

	// Immediate group: a compare is folded into subtract.
	function automatic cls_t grp1(input logic [2:0] sel);
		cls_t r;
		case (sel)
			3'd0: r = CLS_ADD;
			3'd1: r = CLS_OR;
			3'd2: r = CLS_ADC;
			3'd3: r = CLS_SBB;
			3'd4: r = CLS_AND;
			3'd5: r = CLS_SUB;
			3'd6: r = CLS_XOR;
			default: r = CLS_SUB;
		endcase
		return r;
	endfunction

	// Shift and rotate group; the undocumented member acts as a left shift.
	function automatic cls_t grp2(input logic [2:0] sel);
		cls_t r;
		case (sel)
			3'd0: r = CLS_ROL;
			3'd1: r = CLS_ROR;
			3'd2: r = CLS_RCL;
			3'd3: r = CLS_RCR;
			3'd4: r = CLS_SHL;
			3'd5: r = CLS_SHR;
			3'd6: r = CLS_SHL;
			default: r = CLS_SAR;
		endcase
		return r;
	endfunction

	// Unary group; member one has no meaning and is caught by the caller.
	function automatic cls_t grp3(input logic [2:0] sel);
		cls_t r;
		case (sel)
			3'd0: r = CLS_AND;
			3'd2: r = CLS_NOT;
			3'd3: r = CLS_NEG;
			3'd4: r = CLS_MUL;
			3'd5: r = CLS_IMUL;
			3'd6: r = CLS_DIV;
			3'd7: r = CLS_IDIV;
			default: r = CLS_NONE;
		endcase
		return r;
	endfunction

	// Opcode FF group; the last member has no meaning.
	function automatic cls_t grp5(input logic [2:0] sel);
		cls_t r;
		case (sel)
			3'd0: r = CLS_INC;
			3'd1: r = CLS_DEC;
			3'd2: r = CLS_JMP;
			3'd3: r = CLS_JMPF;
			3'd4: r = CLS_JMP;
			3'd5: r = CLS_JMPF;
			3'd6: r = CLS_PUSH;
			default: r = CLS_NONE;
		endcase
		return r;
	endfunction

	function automatic cls_t jcc(input logic [3:0] cond);
		cls_t r;
		case (cond)
			4'h0: r = CLS_JO;
			4'h1: r = CLS_JNO;
			4'h2: r = CLS_JB;
			4'h3: r = CLS_JAE;
			4'h4: r = CLS_JE;
			4'h5: r = CLS_JNE;
			4'h6: r = CLS_JBE;
			4'h7: r = CLS_JA;
			4'h8: r = CLS_JS;
			4'h9: r = CLS_JNS;
			4'hA: r = CLS_JP;
			4'hB: r = CLS_JNP;
			4'hC: r = CLS_JGE;
			4'hD: r = CLS_JL;
			4'hE: r = CLS_JLE;
			default: r = CLS_JG;
		endcase
		return r;
	endfunction

endpackage

FILE: sv/x86oc_decode.sv
// ============================================================================
// x86 opcode class decode logic
// Combinational map from opcode and ModR/M reg field to a mnemonic class.
// ============================================================================
module x86oc_decode (
	input  logic [7:0]        opcode_byte,
	input  logic [7:0]        modrm_byte,
	output x86oc_pkg::decode_t result
);

	logic [7:0]        op;
	logic [2:0]        modrm_reg;
	x86oc_pkg::cls_t   cls;
	logic              ok;

	assign op        = opcode_byte;
	assign modrm_reg = modrm_byte[5:3];

	always_comb begin
		cls = x86oc_pkg::CLS_NONE;
		ok  = 1'b1;
		if (op < 8'h40 && op[2:0] < 3'd6) begin
			cls = x86oc_pkg::alu_row(op[5:3]);
		end else if (op[7:3] == 5'b01000) begin
			cls = x86oc_pkg::CLS_INC;
		end else if (op[7:3] == 5'b01001) begin
			cls = x86oc_pkg::CLS_DEC;
		end else if (op[7:3] == 5'b01010) begin
			cls = x86oc_pkg::CLS_PUSH;
		end else if (op[7:3] == 5'b01011) begin
			cls = x86oc_pkg::CLS_POP;
		end else if (op[7:4] == 4'h7) begin
			cls = x86oc_pkg::jcc(op[3:0]);
		end else if (op[7:2] == 6'b100000) begin
			cls = x86oc_pkg::grp1(modrm_reg);
		end else if (op > 8'h90 && op < 8'h98) begin
			cls = x86oc_pkg::CLS_XCHG;
		end else if (op[7:2] == 6'b101000 || op[7:4] == 4'hB) begin
			cls = x86oc_pkg::CLS_MOV;
		end else begin
			case (op)
				8'h06, 8'h0E, 8'h16, 8'h1E, 8'h68, 8'h6A: cls = x86oc_pkg::CLS_PUSH;
				8'h07, 8'h17, 8'h1F, 8'h8F:               cls = x86oc_pkg::CLS_POP;
				8'h27: cls = x86oc_pkg::CLS_DAA;
				8'h2F: cls = x86oc_pkg::CLS_DAS;
				8'h37: cls = x86oc_pkg::CLS_AAA;
				8'h3F: cls = x86oc_pkg::CLS_AAS;
				8'h60: cls = x86oc_pkg::CLS_PUSHA;
				8'h61: cls = x86oc_pkg::CLS_POPA;
				8'h69, 8'h6B: cls = x86oc_pkg::CLS_IMUL;
				8'h6C, 8'h6D: cls = x86oc_pkg::CLS_INS;
				8'h6E, 8'h6F: cls = x86oc_pkg::CLS_OUTS;
				// TEST shares the AND class.
				8'h84, 8'h85, 8'hA8, 8'hA9: cls = x86oc_pkg::CLS_AND;
				8'h86, 8'h87: cls = x86oc_pkg::CLS_XCHG;
				8'h88, 8'h89, 8'h8A, 8'h8B, 8'h8C, 8'h8E, 8'hC6, 8'hC7:
					cls = x86oc_pkg::CLS_MOV;
				8'h8D: cls = x86oc_pkg::CLS_LEA;
				8'h90: cls = x86oc_pkg::CLS_NOP;
				8'h98: cls = x86oc_pkg::CLS_CBW;
				8'h99: cls = x86oc_pkg::CLS_CWD;
				8'h9A: cls = x86oc_pkg::CLS_CALLF;
				8'h9B: cls = x86oc_pkg::CLS_WAIT;
				8'h9C: cls = x86oc_pkg::CLS_PUSHF;
				8'h9D: cls = x86oc_pkg::CLS_POPF;
				8'h9E: cls = x86oc_pkg::CLS_SAHF;
				8'h9F: cls = x86oc_pkg::CLS_LAHF;
				8'hA4, 8'hA5: cls = x86oc_pkg::CLS_MOVS;
				8'hA6, 8'hA7: cls = x86oc_pkg::CLS_CMPS;
				8'hAA, 8'hAB: cls = x86oc_pkg::CLS_STOS;
				8'hAC, 8'hAD: cls = x86oc_pkg::CLS_LODS;
				8'hAE, 8'hAF: cls = x86oc_pkg::CLS_SCAS;
				8'hC0, 8'hC1, 8'hD0, 8'hD1, 8'hD2, 8'hD3:
					cls = x86oc_pkg::grp2(modrm_reg);
				8'hC2, 8'hC3, 8'hCA, 8'hCB: cls = x86oc_pkg::CLS_RET;
				8'hC4: cls = x86oc_pkg::CLS_LES;
				8'hC5: cls = x86oc_pkg::CLS_LDS;
				// The breakpoint opcode is reported as a far jump.
				8'hCC, 8'hEA: cls = x86oc_pkg::CLS_JMPF;
				8'hCD: cls = x86oc_pkg::CLS_INT;
				8'hCE: cls = x86oc_pkg::CLS_INTO;
				8'hCF: cls = x86oc_pkg::CLS_IRET;
				8'hD4: cls = x86oc_pkg::CLS_AAM;
				8'hD5: cls = x86oc_pkg::CLS_AAD;
				8'hD7: cls = x86oc_pkg::CLS_XLAT;
				8'hE0: cls = x86oc_pkg::CLS_LOOPNZ;
				8'hE1: cls = x86oc_pkg::CLS_LOOPZ;
				8'hE2: cls = x86oc_pkg::CLS_LOOP;
				8'hE3: cls = x86oc_pkg::CLS_JCXZ;
				8'hE4, 8'hE5, 8'hEC, 8'hED: cls = x86oc_pkg::CLS_IN;
				8'hE6, 8'hE7, 8'hEE, 8'hEF: cls = x86oc_pkg::CLS_OUT;
				8'hE8: cls = x86oc_pkg::CLS_CALL;
				8'hE9, 8'hEB: cls = x86oc_pkg::CLS_JMP;
				8'hF4: cls = x86oc_pkg::CLS_HLT;
				8'hF5: cls = x86oc_pkg::CLS_CMC;
				8'hF6, 8'hF7: begin
					cls = x86oc_pkg::grp3(modrm_reg);
					ok  = (modrm_reg != 3'd1);
				end
				8'hF8: cls = x86oc_pkg::CLS_CLC;
				8'hF9: cls = x86oc_pkg::CLS_STC;
				8'hFA: cls = x86oc_pkg::CLS_CLI;
				8'hFB: cls = x86oc_pkg::CLS_STI;
				8'hFC: cls = x86oc_pkg::CLS_CLD;
				8'hFD: cls = x86oc_pkg::CLS_STD;
				8'hFE: begin
					cls = modrm_reg[0] ? x86oc_pkg::CLS_DEC : x86oc_pkg::CLS_INC;
					ok  = (modrm_reg[2:1] == 2'b00);
				end
				8'hFF: begin
					cls = x86oc_pkg::grp5(modrm_reg);
					ok  = (modrm_reg != 3'd7);
				end
				default: ok = 1'b0;
			endcase
		end
	end

	// An unrecognized encoding always reports class zero.
	assign result.mnemonic_class = ok ? cls : x86oc_pkg::CLS_NONE;
	assign result.decode_valid   = ok;

endmodule

FILE: sv/x86_16_opcode_class_decoder_top.sv
// ============================================================================
// x86 16-bit opcode class decoder
// Classifies one opcode/ModR/M pair per cycle, unless the output stalls, into a mnemonic class index.
// ============================================================================
// Usage:
//   Input stream s_axis: tdata carries the opcode byte in bits 7:0 and the
//   ModR/M byte in bits 15:8. A transfer happens when tvalid and tready are
//   both high at a rising clock edge.
//   Output stream m_axis: tdata carries the 7-bit mnemonic class (bit 7 is
//   zero), tuser carries the decode valid flag. One result per input.
//   A result is offered on m_axis once its input transfer has passed the
//   input register, the decode logic and then the result register; an output
//   stall can hold it in the input register.
//   Throughput is one item per cycle while m_axis_tready stays high; the
//   only logic between the two registers is the opcode decode table.
//   When the receiver holds m_axis_tready low, the result register holds its
//   transfer and the input register fills behind it; s_axis_tready then drops
//   until the output moves again. No item is dropped or repeated.
//   Reset (arst_n low) empties both registers at once; no results appear
//   until new inputs arrive.
// ============================================================================
module x86_16_opcode_class_decoder_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [15:0] s_axis_tdata,   // [7:0] opcode_byte, [15:8] modrm_byte
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [7:0]  m_axis_tdata,   // [6:0] mnemonic_class, [7] zero fill
	output logic        m_axis_tuser    // [0] decode_valid
);

	logic               valid_s1;
	logic [7:0]         opcode_s1;
	logic [7:0]         modrm_s1;
	logic               valid_s2;
	x86oc_pkg::decode_t result_s2;
	x86oc_pkg::decode_t decoded;
	logic               advance;
	logic               in_xfer;

	// The pipe moves whenever the result register is empty or being drained.
	assign advance       = !valid_s2 || m_axis_tready;
	assign s_axis_tready = !valid_s1 || advance;
	assign in_xfer       = s_axis_tvalid && s_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (s_axis_tready) begin
				valid_s1 <= s_axis_tvalid;
			end
			if (advance) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			opcode_s1 <= s_axis_tdata[7:0];
			modrm_s1  <= s_axis_tdata[15:8];
		end
		if (advance && valid_s1) begin
			result_s2 <= decoded;
		end
	end

	x86oc_decode u_decode (
		.opcode_byte (opcode_s1),
		.modrm_byte  (modrm_s1),
		.result      (decoded)
	);

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata  = {1'b0, result_s2.mnemonic_class};
	assign m_axis_tuser  = result_s2.decode_valid;

endmodule

FILE: sv/x86oc_checker.sv
// ============================================================================
// x86 opcode class decoder port checker
// Watches the top-level ports for stream and result consistency.
// ============================================================================
`include "x86_16_opcode_class_decoder_top_defines.svh"

module x86oc_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic [15:0] s_axis_tdata,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [7:0]  m_axis_tdata,
	input logic        m_axis_tuser
);

	logic in_xfer;

	assign in_xfer = s_axis_tvalid && s_axis_tready;

	// A stalled result stays offered with the same contents.
	`X86OC_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))

	// An invalid decode always carries class zero.
	`X86OC_ASSERT_IMPL(a_invalid_zero, m_axis_tvalid && !m_axis_tuser, m_axis_tdata == 8'd0)

	// The class index never leaves the mnemonic list.
	`X86OC_ASSERT_IMPL(a_class_range, m_axis_tvalid, m_axis_tdata <= 8'd116)

	// A result appearing on an empty output comes from an input transfer that passed straight through both registers.
	`X86OC_ASSERT_IMPL(a_latency, $rose(m_axis_tvalid), $past(in_xfer, 2))

endmodule

bind x86_16_opcode_class_decoder_top x86oc_checker u_x86oc_checker (.*);

FILE: tb/x86_16_opcode_class_decoder_checker.sv
`timescale 1ns / 1ps
// ============================================================================
// x86 opcode class decoder result checker
// Watches both stream channels, works out the mnemonic class of every input
// transfer and compares it with the matching output transfer, in order.
// ============================================================================
module x86_16_opcode_class_decoder_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	input  logic        s_axis_tready,
	input  logic [15:0] s_axis_tdata,   // [7:0] opcode_byte, [15:8] modrm_byte
	input  logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	input  logic [7:0]  m_axis_tdata,   // [6:0] mnemonic_class, [7] zero fill
	input  logic        m_axis_tuser,   // [0] decode_valid
	output int          fail_count,
	output int          pending
);

	x86oc_pkg::decode_t expected_classes[$];
	x86oc_pkg::decode_t want;

	function automatic x86oc_pkg::decode_t predict_class(input logic [7:0] op,
		input logic [7:0] modrm);
		logic [2:0]         sel;
		x86oc_pkg::cls_t    arith_c;
		x86oc_pkg::cls_t    shift_c;
		x86oc_pkg::cls_t    unary_c;
		x86oc_pkg::cls_t    ffgrp_c;
		x86oc_pkg::cls_t    jcc_c;
		x86oc_pkg::cls_t    c;
		logic               ok;
		x86oc_pkg::decode_t d;
		// Primary arithmetic rows take the operation from the opcode itself,
		// the immediate group takes it from the ModR/M reg field.
		sel = (op[7:6] == 2'b00) ? op[5:3] : modrm[5:3];
		case (sel)
			3'd0: arith_c = x86oc_pkg::CLS_ADD;
			3'd1: arith_c = x86oc_pkg::CLS_OR;
			3'd2: arith_c = x86oc_pkg::CLS_ADC;
			3'd3: arith_c = x86oc_pkg::CLS_SBB;
			3'd4: arith_c = x86oc_pkg::CLS_AND;
			3'd5: arith_c = x86oc_pkg::CLS_SUB;
			3'd6: arith_c = x86oc_pkg::CLS_XOR;
			default: arith_c = (op[7:6] == 2'b00) ? x86oc_pkg::CLS_CMP
				: x86oc_pkg::CLS_SUB;
		endcase
		sel = modrm[5:3];
		case (sel)
			3'd0: shift_c = x86oc_pkg::CLS_ROL;
			3'd1: shift_c = x86oc_pkg::CLS_ROR;
			3'd2: shift_c = x86oc_pkg::CLS_RCL;
			3'd3: shift_c = x86oc_pkg::CLS_RCR;
			3'd5: shift_c = x86oc_pkg::CLS_SHR;
			3'd7: shift_c = x86oc_pkg::CLS_SAR;
			default: shift_c = x86oc_pkg::CLS_SHL;
		endcase
		case (sel)
			3'd0: unary_c = x86oc_pkg::CLS_AND;
			3'd2: unary_c = x86oc_pkg::CLS_NOT;
			3'd3: unary_c = x86oc_pkg::CLS_NEG;
			3'd4: unary_c = x86oc_pkg::CLS_MUL;
			3'd5: unary_c = x86oc_pkg::CLS_IMUL;
			3'd6: unary_c = x86oc_pkg::CLS_DIV;
			3'd7: unary_c = x86oc_pkg::CLS_IDIV;
			default: unary_c = x86oc_pkg::CLS_NONE;
		endcase
		case (sel)
			3'd0: ffgrp_c = x86oc_pkg::CLS_INC;
			3'd1: ffgrp_c = x86oc_pkg::CLS_DEC;
			3'd2, 3'd4: ffgrp_c = x86oc_pkg::CLS_JMP;
			3'd3, 3'd5: ffgrp_c = x86oc_pkg::CLS_JMPF;
			default: ffgrp_c = x86oc_pkg::CLS_PUSH;
		endcase
		// Condition codes C and D map to the greater-or-equal and less classes
		// in that order.
		case (op[3:0])
			4'h0: jcc_c = x86oc_pkg::CLS_JO;
			4'h1: jcc_c = x86oc_pkg::CLS_JNO;
			4'h2: jcc_c = x86oc_pkg::CLS_JB;
			4'h3: jcc_c = x86oc_pkg::CLS_JAE;
			4'h4: jcc_c = x86oc_pkg::CLS_JE;
			4'h5: jcc_c = x86oc_pkg::CLS_JNE;
			4'h6: jcc_c = x86oc_pkg::CLS_JBE;
			4'h7: jcc_c = x86oc_pkg::CLS_JA;
			4'h8: jcc_c = x86oc_pkg::CLS_JS;
			4'h9: jcc_c = x86oc_pkg::CLS_JNS;
			4'hA: jcc_c = x86oc_pkg::CLS_JP;
			4'hB: jcc_c = x86oc_pkg::CLS_JNP;
			4'hC: jcc_c = x86oc_pkg::CLS_JGE;
			4'hD: jcc_c = x86oc_pkg::CLS_JL;
			4'hE: jcc_c = x86oc_pkg::CLS_JLE;
			default: jcc_c = x86oc_pkg::CLS_JG;
		endcase
		ok = 1'b1;
		c = x86oc_pkg::CLS_NONE;
		casez (op)
			8'b00???0??, 8'b00???10?: c = arith_c;
			8'b01000???: c = x86oc_pkg::CLS_INC;
			8'b01001???: c = x86oc_pkg::CLS_DEC;
			8'b01010???: c = x86oc_pkg::CLS_PUSH;
			8'b01011???: c = x86oc_pkg::CLS_POP;
			8'b0111????: c = jcc_c;
			8'b100000??: c = arith_c;
			8'h90: c = x86oc_pkg::CLS_NOP;
			8'b10010???: c = x86oc_pkg::CLS_XCHG;
			8'b101000??, 8'b1011????: c = x86oc_pkg::CLS_MOV;
			8'h06, 8'h0E, 8'h16, 8'h1E, 8'h68, 8'h6A: c = x86oc_pkg::CLS_PUSH;
			8'h07, 8'h17, 8'h1F, 8'h8F: c = x86oc_pkg::CLS_POP;
			8'h27: c = x86oc_pkg::CLS_DAA;
			8'h2F: c = x86oc_pkg::CLS_DAS;
			8'h37: c = x86oc_pkg::CLS_AAA;
			8'h3F: c = x86oc_pkg::CLS_AAS;
			8'h60: c = x86oc_pkg::CLS_PUSHA;
			8'h61: c = x86oc_pkg::CLS_POPA;
			8'h69, 8'h6B: c = x86oc_pkg::CLS_IMUL;
			8'h6C, 8'h6D: c = x86oc_pkg::CLS_INS;
			8'h6E, 8'h6F: c = x86oc_pkg::CLS_OUTS;
			8'h84, 8'h85, 8'hA8, 8'hA9: c = x86oc_pkg::CLS_AND;
			8'h86, 8'h87: c = x86oc_pkg::CLS_XCHG;
			8'h88, 8'h89, 8'h8A, 8'h8B, 8'h8C, 8'h8E, 8'hC6, 8'hC7:
				c = x86oc_pkg::CLS_MOV;
			8'h8D: c = x86oc_pkg::CLS_LEA;
			8'h98: c = x86oc_pkg::CLS_CBW;
			8'h99: c = x86oc_pkg::CLS_CWD;
			8'h9A: c = x86oc_pkg::CLS_CALLF;
			8'h9B: c = x86oc_pkg::CLS_WAIT;
			8'h9C: c = x86oc_pkg::CLS_PUSHF;
			8'h9D: c = x86oc_pkg::CLS_POPF;
			8'h9E: c = x86oc_pkg::CLS_SAHF;
			8'h9F: c = x86oc_pkg::CLS_LAHF;
			8'hA4, 8'hA5: c = x86oc_pkg::CLS_MOVS;
			8'hA6, 8'hA7: c = x86oc_pkg::CLS_CMPS;
			8'hAA, 8'hAB: c = x86oc_pkg::CLS_STOS;
			8'hAC, 8'hAD: c = x86oc_pkg::CLS_LODS;
			8'hAE, 8'hAF: c = x86oc_pkg::CLS_SCAS;
			8'hC0, 8'hC1, 8'hD0, 8'hD1, 8'hD2, 8'hD3: c = shift_c;
			8'hC2, 8'hC3, 8'hCA, 8'hCB: c = x86oc_pkg::CLS_RET;
			8'hC4: c = x86oc_pkg::CLS_LES;
			8'hC5: c = x86oc_pkg::CLS_LDS;
			8'hCC, 8'hEA: c = x86oc_pkg::CLS_JMPF;
			8'hCD: c = x86oc_pkg::CLS_INT;
			8'hCE: c = x86oc_pkg::CLS_INTO;
			8'hCF: c = x86oc_pkg::CLS_IRET;
			8'hD4: c = x86oc_pkg::CLS_AAM;
			8'hD5: c = x86oc_pkg::CLS_AAD;
			8'hD7: c = x86oc_pkg::CLS_XLAT;
			8'hE0: c = x86oc_pkg::CLS_LOOPNZ;
			8'hE1: c = x86oc_pkg::CLS_LOOPZ;
			8'hE2: c = x86oc_pkg::CLS_LOOP;
			8'hE3: c = x86oc_pkg::CLS_JCXZ;
			8'hE4, 8'hE5, 8'hEC, 8'hED: c = x86oc_pkg::CLS_IN;
			8'hE6, 8'hE7, 8'hEE, 8'hEF: c = x86oc_pkg::CLS_OUT;
			8'hE8: c = x86oc_pkg::CLS_CALL;
			8'hE9, 8'hEB: c = x86oc_pkg::CLS_JMP;
			8'hF4: c = x86oc_pkg::CLS_HLT;
			8'hF5: c = x86oc_pkg::CLS_CMC;
			8'hF6, 8'hF7: begin
				c = unary_c;
				ok = (sel != 3'd1);
			end
			8'hF8: c = x86oc_pkg::CLS_CLC;
			8'hF9: c = x86oc_pkg::CLS_STC;
			8'hFA: c = x86oc_pkg::CLS_CLI;
			8'hFB: c = x86oc_pkg::CLS_STI;
			8'hFC: c = x86oc_pkg::CLS_CLD;
			8'hFD: c = x86oc_pkg::CLS_STD;
			8'hFE: begin
				c = ffgrp_c;
				ok = (sel <= 3'd1);
			end
			8'hFF: begin
				c = ffgrp_c;
				ok = (sel != 3'd7);
			end
			default: ok = 1'b0;
		endcase
		if (!ok)
			c = x86oc_pkg::CLS_NONE;
		d.mnemonic_class = c;
		d.decode_valid = ok;
		return d;
	endfunction

	initial begin
		fail_count = 0;
		pending = 0;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (expected_classes.size() == 0) begin
					$error("unexpected result transfer: tdata=%h tuser=%b",
						m_axis_tdata, m_axis_tuser);
					fail_count = fail_count + 1;
				end else begin
					want = expected_classes.pop_front();
					if (m_axis_tdata[6:0] !== want.mnemonic_class) begin
						$error("mnemonic_class: expected %0d, actual %0d",
							want.mnemonic_class, m_axis_tdata[6:0]);
						fail_count = fail_count + 1;
					end
					if (m_axis_tuser !== want.decode_valid) begin
						$error("decode_valid: expected %b, actual %b",
							want.decode_valid, m_axis_tuser);
						fail_count = fail_count + 1;
					end
					if (m_axis_tdata[7] !== 1'b0) begin
						$error("tdata fill bit: expected 0, actual %b", m_axis_tdata[7]);
						fail_count = fail_count + 1;
					end
				end
			end
			if (s_axis_tvalid && s_axis_tready)
				expected_classes.push_back(predict_class(s_axis_tdata[7:0],
					s_axis_tdata[15:8]));
			pending = expected_classes.size();
		end
	end

endmodule

FILE: tb/tb.sv
`timescale 1ns / 1ps
// ============================================================================
// x86 opcode class decoder testbench
// Drives opcode/ModR/M pairs through the input stream with random gaps and
// output stalls, including one long stall that backs up the input, and lets
// the checker compare every result with the predicted class.
// ============================================================================
module tb;

	localparam logic [7:0] OP_CMP_RM   = 8'h38;
	localparam logic [7:0] OP_LEA      = 8'h8D;
	localparam logic [7:0] OP_INT3     = 8'hCC;
	localparam logic [7:0] OP_ARPL     = 8'h63;
	localparam logic [7:0] OP_SALC     = 8'hD6;
	localparam int         RANDOM_ITEMS = 700;
	localparam int         QUIET_ITEMS  = 100;
	localparam int         PRESSURE_AT  = 300;
	localparam int         PRESSURE_LEN = 80;

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [15:0] s_axis_tdata;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [7:0]  m_axis_tdata;
	logic        m_axis_tuser;
	int          fail_count;
	int          pending;
	int          sent_count;
	bit          quiet;

	x86_16_opcode_class_decoder_top u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	x86_16_opcode_class_decoder_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.fail_count    (fail_count),
		.pending       (pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = 16'h0000;
		m_axis_tready = 1'b0;
		sent_count = 0;
		quiet = 1'b0;
		repeat (9) @(negedge clk);
		arst_n <= 1'b1;
	end

	// Offers one pair and holds it until the transfer, sometimes after a gap.
	task automatic send_pair(input logic [7:0] op, input logic [7:0] modrm);
		int gap;
		gap = (!quiet && $urandom_range(0, 5) == 0) ? $urandom_range(1, 15) : 0;
		@(negedge clk);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata <= 16'($urandom);
			repeat (gap) @(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {modrm, op};
		do
			@(posedge clk);
		while (!s_axis_tready);
		sent_count = sent_count + 1;
	endtask

	// Receiver: random stall bursts, one long hold-off, none near the end.
	initial begin
		int  stall_left;
		bit  pressure_done;
		stall_left = 0;
		pressure_done = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (stall_left == 0 && !pressure_done && sent_count >= PRESSURE_AT) begin
				stall_left = PRESSURE_LEN;
				pressure_done = 1'b1;
			end else if (stall_left == 0 && !quiet && $urandom_range(0, 7) == 0) begin
				stall_left = $urandom_range(1, 15);
			end
			if (stall_left > 0) begin
				stall_left = stall_left - 1;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	initial begin
		int         base;
		logic [7:0] op;
		@(posedge arst_n);
		// Field extremes, the merged classes and the invalid corners.
		send_pair(8'h00, 8'h00);
		send_pair(8'h3D, 8'hFF);
		send_pair(OP_CMP_RM, 8'h00);
		send_pair(8'h3F, 8'hFF);
		send_pair(OP_LEA, 8'h00);
		send_pair(OP_INT3, 8'hFF);
		send_pair(OP_ARPL, 8'h00);
		send_pair(OP_SALC, 8'hFF);
		send_pair(8'h84, 8'h00);
		send_pair(8'hA9, 8'hFF);
		send_pair(8'h80, 8'h38);
		send_pair(8'h83, 8'hC7);
		send_pair(8'hD0, 8'h30);
		send_pair(8'hC1, 8'h38);
		send_pair(8'hF6, 8'h00);
		send_pair(8'hF7, 8'h08);
		send_pair(8'hF6, 8'hF8);
		send_pair(8'hFE, 8'h10);
		send_pair(8'hFE, 8'h08);
		send_pair(8'hFF, 8'h38);
		send_pair(8'hFF, 8'h30);
		send_pair(8'h0F, 8'h00);
		send_pair(8'hD8, 8'hFF);
		send_pair(8'hC8, 8'h00);
		send_pair(8'h7C, 8'h00);
		send_pair(8'h7D, 8'hFF);
		send_pair(8'hFF, 8'hFF);

		// The first pass visits every opcode once in a scrambled order; after
		// that half of the pairs land on the group opcodes.
		base = $urandom_range(0, 255);
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			if (i >= RANDOM_ITEMS - QUIET_ITEMS)
				quiet = 1'b1;
			if (i < 256) begin
				op = 8'((i * 167 + base) & 255);
			end else if ($urandom_range(0, 1) == 0) begin
				case ($urandom_range(0, 4))
					0: op = 8'h80 | 8'($urandom_range(0, 3));
					1: op = 8'hD0 | 8'($urandom_range(0, 3));
					2: op = 8'hC0 | 8'($urandom_range(0, 1));
					3: op = 8'hF6 | 8'($urandom_range(0, 1));
					default: op = 8'hFE | 8'($urandom_range(0, 1));
				endcase
			end else begin
				op = 8'($urandom_range(0, 255));
			end
			send_pair(op, 8'($urandom_range(0, 255)));
		end
		@(negedge clk);
		s_axis_tvalid <= 1'b0;

		wait (pending == 0);
		repeat (10) @(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("FAILED: results differ");
		$finish;
	end

endmodule

FILE: sim.f
+incdir+sv
sv/x86oc_pkg.sv
sv/x86oc_decode.sv
sv/x86_16_opcode_class_decoder_top.sv
sv/x86oc_checker.sv
tb/x86_16_opcode_class_decoder_checker.sv
tb/tb.sv
